[rtl/pltd_pkg.sv]
// pltd_pkg: shared constants and the token and report types of the prime chain
// used by pltd_cell, pltd_ctrl and the top level prime_list_by_trial_division
// no dependencies
`default_nettype none

package pltd_pkg;

	localparam int unsigned MAX_LIMIT   = 311;
	localparam int unsigned MAX_PRIMES  = 64;
	localparam int unsigned FIRST_PRIME = 2;

	localparam int unsigned VAL_W = 9;
	localparam int unsigned IDX_W = 6;
	localparam int unsigned CNT_W = 7;

	// candidate travelling down the chain of cells
	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] cand;
		logic             composite;
	} tok_t;

	// verdict from the cell where a candidate came to rest
	typedef struct packed {
		logic done;
		logic prime;
	} rpt_t;

endpackage

`default_nettype wire

[rtl/pltd_cell.sv]
// pltd_cell: one cell of the prime chain, holds a prime and the candidate residue modulo it
// depends on pltd_pkg
`default_nettype none

module pltd_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          clr,
	input  wire pltd_pkg::tok_t tok_in,
	output pltd_pkg::tok_t     tok_out,
	output pltd_pkg::rpt_t     rpt
);
	import pltd_pkg::*;

	logic             v_q;
	logic [VAL_W-1:0] p_q;
	logic [VAL_W-1:0] r_q;
	logic [VAL_W-1:0] r_inc;
	logic [VAL_W-1:0] r_nxt;
	tok_t             tok_q;
	rpt_t             rpt_q;

	// residue steps by one per candidate, wrapping at the held prime
	assign r_inc = r_q + VAL_W'(1);
	assign r_nxt = (r_inc == p_q) ? '0 : r_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= 1'b0;
			tok_q <= '0;
			rpt_q <= '0;
		end else if (clr) begin
			v_q   <= 1'b0;
			tok_q <= '0;
			rpt_q <= '0;
		end else begin
			tok_q.valid     <= tok_in.valid & v_q;
			tok_q.cand      <= tok_in.cand;
			tok_q.composite <= tok_in.composite | (r_nxt == '0);
			rpt_q.done      <= tok_in.valid & ~v_q;
			rpt_q.prime     <= ~tok_in.composite;
			if (tok_in.valid && !v_q && !tok_in.composite) begin
				v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.valid) begin
			if (v_q) begin
				r_q <= r_nxt;
			end else if (!tok_in.composite) begin
				// first empty cell takes the new prime
				p_q <= tok_in.cand;
				r_q <= '0;
			end
		end
	end

	assign tok_out = tok_q;
	assign rpt     = rpt_q;

endmodule

`default_nettype wire

[rtl/pltd_ctrl.sv]
// pltd_ctrl: request sequencer, issues candidates into the chain and assembles result beats
// depends on pltd_pkg
`default_nettype none

module pltd_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire logic [pltd_pkg::VAL_W-1:0]  req_limit,
	output logic                             clr,
	output pltd_pkg::tok_t                   tok,
	input  wire pltd_pkg::rpt_t              rpt,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output logic [pltd_pkg::VAL_W-1:0]       res_value,
	output logic [pltd_pkg::IDX_W-1:0]       res_index,
	output logic [pltd_pkg::CNT_W-1:0]       res_count,
	output logic                             res_found,
	output logic                             res_last
);
	import pltd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_DECIDE,
		ST_FLUSH
	} state_t;

	state_t           state_q;
	logic [VAL_W-1:0] lim_q;
	logic [VAL_W-1:0] cand_q;
	logic [CNT_W-1:0] cnt_q;
	logic             prime_q;
	logic             pend_v_q;
	logic [VAL_W-1:0] pend_val_q;
	logic [IDX_W-1:0] pend_idx_q;
	logic             clr_q;
	tok_t             tok_q;
	logic             out_v_q;
	logic [VAL_W-1:0] out_val_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic             out_found_q;
	logic             out_last_q;
	logic             out_free;
	logic [VAL_W-1:0] lim_sat;

	assign out_free  = ~out_v_q | res_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign lim_sat   = (req_limit > VAL_W'(MAX_LIMIT)) ? VAL_W'(MAX_LIMIT) : req_limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lim_q       <= '0;
			cand_q      <= '0;
			cnt_q       <= '0;
			prime_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_val_q  <= '0;
			pend_idx_q  <= '0;
			clr_q       <= 1'b0;
			tok_q       <= '0;
			out_v_q     <= 1'b0;
			out_val_q   <= '0;
			out_idx_q   <= '0;
			out_cnt_q   <= '0;
			out_found_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			clr_q       <= 1'b0;
			tok_q.valid <= 1'b0;
			if (res_ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						lim_q    <= lim_sat;
						cand_q   <= VAL_W'(FIRST_PRIME);
						cnt_q    <= '0;
						pend_v_q <= 1'b0;
						clr_q    <= 1'b1;
						state_q  <= (lim_sat < VAL_W'(FIRST_PRIME)) ? ST_FLUSH : ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (cand_q > lim_q || cnt_q == CNT_W'(MAX_PRIMES)) begin
						state_q <= ST_FLUSH;
					end else begin
						tok_q.valid     <= 1'b1;
						tok_q.cand      <= cand_q;
						tok_q.composite <= 1'b0;
						state_q         <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (rpt.done) begin
						prime_q <= rpt.prime;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!prime_q) begin
						cand_q  <= cand_q + VAL_W'(1);
						state_q <= ST_ISSUE;
					end else if (!pend_v_q || out_free) begin
						// earlier prime is not the last one, send it on
						if (pend_v_q) begin
							out_v_q     <= 1'b1;
							out_val_q   <= pend_val_q;
							out_idx_q   <= pend_idx_q;
							out_cnt_q   <= '0;
							out_found_q <= 1'b1;
							out_last_q  <= 1'b0;
						end
						pend_v_q   <= 1'b1;
						pend_val_q <= cand_q;
						pend_idx_q <= cnt_q[IDX_W-1:0];
						cnt_q      <= cnt_q + CNT_W'(1);
						cand_q     <= cand_q + VAL_W'(1);
						state_q    <= ST_ISSUE;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						out_v_q     <= 1'b1;
						out_val_q   <= pend_v_q ? pend_val_q : '0;
						out_idx_q   <= pend_v_q ? pend_idx_q : '0;
						out_cnt_q   <= cnt_q;
						out_found_q <= pend_v_q;
						out_last_q  <= 1'b1;
						pend_v_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign clr       = clr_q;
	assign tok       = tok_q;
	assign res_valid = out_v_q;
	assign res_value = out_val_q;
	assign res_index = out_idx_q;
	assign res_count = out_cnt_q;
	assign res_found = out_found_q;
	assign res_last  = out_last_q;

endmodule

`default_nettype wire

[rtl/prime_list_by_trial_division.sv]
// timing: the token walks the chain one cell per cycle up to the first empty cell, which
// reports the verdict; a request takes longer if the output is stalled
// throughput: one request at a time, the next limit is taken once the last beat is queued
// reset: arst_n clears the sequencer, the output register and every cell's valid flag
// top level: chain of MAX_PRIMES cells driven by pltd_ctrl; depends on pltd_pkg, pltd_ctrl, pltd_cell
`default_nettype none

module prime_list_by_trial_division (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [8:0] limit, rest zero
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [8:0] prime_value, [14:9] prime_index,
	                                         // [21:15] prime_count, rest zero
	output logic             m_axis_tlast,   // last
	output logic [0:0]       m_axis_tuser    // [0] found
);
	import pltd_pkg::*;

	tok_t             tok [MAX_PRIMES+1];
	rpt_t             rpt_cell [MAX_PRIMES];
	logic [MAX_PRIMES-1:0] done_vec;
	logic [MAX_PRIMES-1:0] prime_vec;
	rpt_t             rpt_any;
	logic             clr;
	logic [VAL_W-1:0] res_value;
	logic [IDX_W-1:0] res_index;
	logic [CNT_W-1:0] res_count;
	logic             res_found;

	pltd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req_limit (s_axis_tdata[VAL_W-1:0]),
		.clr       (clr),
		.tok       (tok[0]),
		.rpt       (rpt_any),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res_value (res_value),
		.res_index (res_index),
		.res_count (res_count),
		.res_found (res_found),
		.res_last  (m_axis_tlast)
	);

	for (genvar i = 0; i < MAX_PRIMES; i++) begin : g_cell
		pltd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.clr     (clr),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.rpt     (rpt_cell[i])
		);
		assign done_vec[i]  = rpt_cell[i].done;
		assign prime_vec[i] = rpt_cell[i].done & rpt_cell[i].prime;
	end

	// only one candidate is in the chain, so at most one cell reports
	assign rpt_any.done  = |done_vec;
	assign rpt_any.prime = |prime_vec;

	assign m_axis_tdata    = {2'b00, res_count, res_index, res_value};
	assign m_axis_tuser[0] = res_found;

endmodule

`default_nettype wire

[rtl/pltd_chk.sv]
// pltd_chk: port-level checks on the prime list output stream, bound to the top level
// depends on prime_list_by_trial_division port names only
`default_nettype none

module pltd_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [15:0] s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata,
	input wire logic        m_axis_tlast,
	input wire logic [0:0]  m_axis_tuser
);

	// a stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("output beat changed while stalled");

	// empty answer is a single all-zero last beat
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == 24'd0)
		else $error("empty answer malformed");

	// count only on the last beat
	a_mid_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[21:15] == 7'd0 && m_axis_tuser[0])
		else $error("count shown before last beat");

	// final count is one past the final index
	a_last_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && m_axis_tuser[0]
			|-> m_axis_tdata[21:15] == ({1'b0, m_axis_tdata[14:9]} + 7'd1))
		else $error("final count does not match final index");

	// no request is taken back to back
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken back to back");

endmodule

bind prime_list_by_trial_division pltd_chk u_pltd_chk (.*);

`default_nettype wire

[tb/sv/prime_list_checker.sv]
`timescale 1ns / 1ps
// prime_list_checker: watches the limit and prime streams of prime_list_by_trial_division,
// works out the prime list of every accepted limit and compares the output beat by beat
// depends on pltd_pkg
module prime_list_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [8:0] limit
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,   // [8:0] prime_value, [14:9] prime_index,
	                                    // [21:15] prime_count
	input  logic        m_axis_tlast,   // last
	input  logic [0:0]  m_axis_tuser,   // [0] found
	output int          fail_count,
	output int          pending
);
	import pltd_pkg::*;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] index;
		logic [CNT_W-1:0] count;
		logic             found;
		logic             last;
	} prime_beat_t;

	prime_beat_t expected_primes [$];
	int          mismatches = 0;

	// trial division over every divisor below the candidate, stopping at MAX_PRIMES
	function automatic void queue_primes_up_to(input logic [VAL_W-1:0] limit_in);
		int unsigned      top_val;
		int unsigned      cand;
		int unsigned      div;
		int unsigned      total;
		logic [VAL_W-1:0] cand_bits;
		logic [VAL_W-1:0] primes [$];
		bit               composite;
		prime_beat_t      beat;
		top_val = (limit_in > MAX_LIMIT) ? MAX_LIMIT : limit_in;
		cand = FIRST_PRIME;
		while (cand <= top_val && primes.size() < MAX_PRIMES) begin
			composite = 1'b0;
			div = FIRST_PRIME;
			while (div < cand && !composite) begin
				composite = (cand % div == 0);
				div++;
			end
			if (!composite) begin
				cand_bits = VAL_W'(cand);
				primes.push_back(cand_bits);
			end
			cand++;
		end
		total = primes.size();
		// nothing below two: a single empty answer
		if (total == 0) begin
			beat = '0;
			beat.last = 1'b1;
			expected_primes.push_back(beat);
		end
		for (int k = 0; k < total; k++) begin
			beat.value = primes[k];
			beat.index = IDX_W'(k);
			beat.count = (k == total - 1) ? CNT_W'(total) : '0;
			beat.found = 1'b1;
			beat.last  = (k == total - 1);
			expected_primes.push_back(beat);
		end
	endfunction

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : watch
		prime_beat_t want;
		if (!arst_n) begin
			expected_primes.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				queue_primes_up_to(s_axis_tdata[VAL_W-1:0]);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_primes.size() == 0) begin
					$display("%t: unexpected beat, expected none, actual data %h last %b found %b",
						$time, m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
					mismatches++;
				end else begin
					want = expected_primes.pop_front();
					check_field("prime_value", want.value, m_axis_tdata[8:0]);
					check_field("prime_index", want.index, m_axis_tdata[14:9]);
					check_field("prime_count", want.count, m_axis_tdata[21:15]);
					check_field("found", want.found, m_axis_tuser[0]);
					check_field("last", want.last, m_axis_tlast);
				end
			end
		end
		fail_count <= mismatches;
		pending    <= expected_primes.size();
	end

endmodule

[tb/sv/prime_list_by_trial_division_tb.sv]
`timescale 1ns / 1ps
// prime_list_by_trial_division_tb: drives limits into the prime lister and gives the verdict
// depends on pltd_pkg, prime_list_by_trial_division and prime_list_checker
module prime_list_by_trial_division_tb;
	import pltd_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_LIMITS = 100;
	localparam int HOLD_CYCLES   = 3000;
	localparam int DRAIN_CYCLES  = 300;
	localparam int CYCLE_LIMIT   = 8_000_000;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [0:0]  m_axis_tuser;
	int          fail_count;
	int          pending;
	int          cycles = 0;

	// below two, small, the 64th prime, saturation and single-bit patterns
	logic [8:0] corner_limits [16] = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd8, 9'd30,
		9'd31, 9'd97, 9'd256, 9'd255, 9'd310, 9'd311, 9'd312, 9'd511};

	always #CLK_HALF clk = ~clk;

	prime_list_by_trial_division u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	prime_list_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycles, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic offer_limit(input logic [8:0] lim, input bit steady);
		while (!steady && $urandom_range(99) < 30) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, lim};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	initial begin : stimulus
		logic [8:0] lim;
		int         pick;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (corner_limits[i])
			offer_limit(corner_limits[i], 1'b0);
		// mostly small limits, the slow saturated ones only now and then
		for (int n = 0; n < RANDOM_LIMITS; n++) begin
			pick = $urandom_range(99);
			if (pick < 70)
				lim = 9'($urandom_range(63));
			else if (pick < 90)
				lim = 9'($urandom_range(311, 64));
			else
				lim = 9'($urandom_range(511, 312));
			offer_limit(lim, n >= 40 && n < 65);
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : sink
		int beats;
		bit held;
		beats = 0;
		held  = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				beats++;
			// long back-pressure so the lister fills up and stops taking limits
			if (arst_n && !held && beats >= 150) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= (beats >= 400 && beats < 700) || ($urandom_range(99) >= 30);
			end
		end
	end

endmodule
